// ----- hw/rtl/first_free_slot_owner_table_macros.svh -----
// Assertion macros for the slot owner table checker.
// Depends on nothing; included by the files that assert.
`ifndef FIRST_FREE_SLOT_OWNER_TABLE_MACROS_SVH
`define FIRST_FREE_SLOT_OWNER_TABLE_MACROS_SVH

// Same-cycle implication, off during reset
`define FSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, off during reset
`define FSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- hw/rtl/fss_pkg.sv -----
// Shared types and constants for the first-fit slot owner table.
// Used by the interfaces, the free-slot finder, the top level and the checker.
package fss_pkg;

  // Field widths fixed by the transaction format
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 7;
  localparam int OWNER_W = 16;
  localparam int STAT_W  = 2;

  // Largest capacity that the capacity register can hold
  localparam int CAP_MAX = 127;

  // Opcodes
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
  localparam logic [OP_W-1:0] OP_SET     = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FREE = 2'd3;

  // Sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Lowest free slot, zero-based, as found by the search
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } find_t;

endpackage

// ----- hw/rtl/fss_if.sv -----
// Valid/ready channel interfaces for requests and results of the slot table.
// Depends on fss_pkg for field widths.
interface fss_in_if;
  logic                       valid;
  logic                       ready;
  logic [fss_pkg::OP_W-1:0]    opcode;
  logic [fss_pkg::SLOT_W-1:0]  slot_number;
  logic [fss_pkg::OWNER_W-1:0] owner_id;

  modport source (output valid, output opcode, output slot_number, output owner_id,
                  input ready);
  modport sink   (input valid, input opcode, input slot_number, input owner_id,
                  output ready);
endinterface

interface fss_out_if;
  logic                       valid;
  logic                       ready;
  logic [fss_pkg::STAT_W-1:0]  status;
  logic [fss_pkg::SLOT_W-1:0]  result_slot;
  logic [fss_pkg::OWNER_W-1:0] result_owner;
  logic [fss_pkg::SLOT_W-1:0]  free_count;
  logic [fss_pkg::SLOT_W-1:0]  occupied_count_out;

  modport source (output valid, output status, output result_slot, output result_owner,
                  output free_count, output occupied_count_out, input ready);
  modport sink   (input valid, input status, input result_slot, input result_owner,
                  input free_count, input occupied_count_out, output ready);
endinterface

// ----- hw/rtl/fss_find.sv -----
// Registered search for the lowest free slot below the capacity.
// Depends on fss_pkg for the find_t result type.
module fss_find #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [DEPTH-1:0]           occ,
  input  logic [fss_pkg::SLOT_W-1:0] cap,
  output fss_pkg::find_t             res_r
);

  logic [DEPTH-1:0]           free_v;
  logic [DEPTH-1:0]           lowest;
  logic [fss_pkg::SLOT_W-1:0] slot_enc;
  fss_pkg::find_t             res_nxt;

  // Mark slots that are free and inside the capacity
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      free_v[i] = !occ[i] && (fss_pkg::SLOT_W'(i) < cap);
    end
  end

  // Isolate the lowest set bit, then encode its position
  assign lowest = free_v & (~free_v + DEPTH'(1));

  always_comb begin
    slot_enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lowest[i]) begin
        slot_enc = slot_enc | fss_pkg::SLOT_W'(i);
      end
    end
    res_nxt.found = |free_v;
    res_nxt.slot  = slot_enc;
  end

  // Capture the search result with the transaction
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- hw/rtl/first_free_slot_owner_table.sv -----
// First-fit slot owner table. Each transaction is accepted in the idle state and
// finished in the execute state: in the accept cycle the table memory is read at
// the requested slot and the lowest free slot is searched over the occupancy
// bitmap, both into registers; in the execute cycle the entry is modified and
// written back, the counts are updated and the result register is loaded. A new
// request is taken in the cycle after that, also while the previous result still
// waits, as long as the sink takes it then. The owner memory needs no clearing
// pass: a per-slot occupancy flag is cleared at reset and on every capacity write,
// and a slot whose flag is clear reads as free. Depends on fss_pkg, fss_if and fss_find.
module first_free_slot_owner_table #(
  parameter int SLOTS      = 64,
  parameter int OWNER_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fss_in_if.sink                     in_chan,
  fss_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [fss_pkg::SLOT_W-1:0] cfg_wdata
);

  // Only slots reachable through the capacity register get storage
  localparam int USED = (SLOTS < fss_pkg::CAP_MAX) ? SLOTS : fss_pkg::CAP_MAX;
  localparam int IW   = (USED > 1) ? $clog2(USED) : 1;
  localparam logic [fss_pkg::SLOT_W-1:0] CAP_LIM = fss_pkg::SLOT_W'(USED);
  localparam logic [fss_pkg::SLOT_W-1:0] CAP_RST =
    (USED < 64) ? fss_pkg::SLOT_W'(USED) : fss_pkg::SLOT_W'(64);

  fss_pkg::state_t state_r, state_nxt;
  logic            accept;

  logic [OWNER_BITS-1:0] mem [USED];
  logic [OWNER_BITS-1:0] rd_r;

  logic [USED-1:0]            occ_r, occ_nxt;
  logic [fss_pkg::SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [fss_pkg::SLOT_W-1:0] cap_r;

  // Request registers
  logic [fss_pkg::OP_W-1:0] op_r;
  logic [IW-1:0]            idx_r;
  logic                     idx_ok_r;
  logic [OWNER_BITS-1:0]    owner_r;

  // Request decode at accept
  logic [fss_pkg::SLOT_W-1:0]    idx7;
  logic [IW-1:0]                 idx_in;
  logic                          idx_ok_in;
  logic [OWNER_BITS+15:0]        owner_ext;
  logic [OWNER_BITS-1:0]         owner_in;

  fss_pkg::find_t fnd_r;

  // Execute-cycle results
  logic                       mem_we;
  logic [IW-1:0]              mem_wa;
  logic [OWNER_BITS-1:0]      mem_wd;
  logic [fss_pkg::STAT_W-1:0] stat_c;
  logic [fss_pkg::SLOT_W-1:0] rslot_c;
  logic [OWNER_BITS-1:0]      rowner_c;
  logic                       slot_occ;
  logic [OWNER_BITS+15:0]     rowner_ext;

  // Output register
  logic                        out_valid_r;
  logic [fss_pkg::STAT_W-1:0]  status_r;
  logic [fss_pkg::SLOT_W-1:0]  rslot_r;
  logic [fss_pkg::OWNER_W-1:0] rowner_r;
  logic [fss_pkg::SLOT_W-1:0]  free_r;
  logic [fss_pkg::SLOT_W-1:0]  occ_cnt_r;

  // Decode the incoming slot number and mask the owner to the stored width
  assign idx7      = in_chan.slot_number - fss_pkg::SLOT_W'(1);
  assign idx_in    = idx7[IW-1:0];
  assign idx_ok_in = (in_chan.slot_number != '0) && (in_chan.slot_number <= cap_r);
  assign owner_ext = {{OWNER_BITS{1'b0}}, in_chan.owner_id};
  assign owner_in  = owner_ext[OWNER_BITS-1:0];

  // Sequencer: one transaction at a time
  always_comb begin
    state_nxt      = state_r;
    in_chan.ready  = 1'b0;
    unique case (state_r)
      fss_pkg::S_IDLE: begin
        in_chan.ready = !out_valid_r || out_chan.ready;
        if (in_chan.valid && in_chan.ready) begin
          state_nxt = fss_pkg::S_EXEC;
        end
      end
      fss_pkg::S_EXEC: begin
        state_nxt = fss_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fss_pkg::S_IDLE;
      end
    endcase
  end

  assign accept = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Search the lowest free slot alongside the table read
  fss_find #(
    .DEPTH (USED)
  ) u_find (
    .clk   (clk),
    .load  (accept),
    .occ   (occ_r),
    .cap   (cap_r),
    .res_r (fnd_r)
  );

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_chan.opcode;
      idx_r    <= idx_in;
      idx_ok_r <= idx_ok_in;
      owner_r  <= owner_in;
    end
  end

  // Owner memory: read at accept, written back in the execute cycle.
  // The write lands before the next accept reads the memory, so no forwarding.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= mem[idx_in];
    end
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // Modify: work out status, write-back and new counts
  always_comb begin
    slot_occ = idx_ok_r && occ_r[idx_r];
    mem_we   = 1'b0;
    mem_wa   = idx_r;
    mem_wd   = owner_r;
    occ_nxt  = occ_r;
    cnt_nxt  = cnt_r;
    stat_c   = fss_pkg::STAT_OK;
    rslot_c  = '0;
    rowner_c = '0;
    if (state_r == fss_pkg::S_EXEC) begin
      priority if (op_r == fss_pkg::OP_RESERVE) begin
        priority if (owner_r == '0) begin
          stat_c = fss_pkg::STAT_BAD;
        end else if (!fnd_r.found) begin
          stat_c = fss_pkg::STAT_FULL;
        end else begin
          mem_we  = 1'b1;
          mem_wa  = fnd_r.slot[IW-1:0];
          occ_nxt[fnd_r.slot[IW-1:0]] = 1'b1;
          cnt_nxt = cnt_r + fss_pkg::SLOT_W'(1);
          rslot_c = fnd_r.slot + fss_pkg::SLOT_W'(1);
        end
      end else if (!idx_ok_r) begin
        stat_c = fss_pkg::STAT_BAD;
      end else if (op_r == fss_pkg::OP_RELEASE) begin
        if (!slot_occ) begin
          stat_c = fss_pkg::STAT_FREE;
        end else begin
          rowner_c       = rd_r;
          occ_nxt[idx_r] = 1'b0;
          cnt_nxt        = cnt_r - fss_pkg::SLOT_W'(1);
        end
      end else if (op_r == fss_pkg::OP_QUERY) begin
        rowner_c = slot_occ ? rd_r : '0;
      end else begin
        // Set: a nonzero owner occupies the slot, zero frees it
        if (owner_r != '0) begin
          mem_we         = 1'b1;
          occ_nxt[idx_r] = 1'b1;
          if (!slot_occ) begin
            cnt_nxt = cnt_r + fss_pkg::SLOT_W'(1);
          end
        end else begin
          occ_nxt[idx_r] = 1'b0;
          if (slot_occ) begin
            cnt_nxt = cnt_r - fss_pkg::SLOT_W'(1);
          end
        end
      end
    end
  end

  // Table control state; a capacity write clears occupancy and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RST;
      occ_r <= '0;
      cnt_r <= '0;
    end else if (cfg_we) begin
      cap_r <= (cfg_wdata > CAP_LIM) ? CAP_LIM : cfg_wdata;
      occ_r <= '0;
      cnt_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign rowner_ext = {16'b0, rowner_c};

  // Output register: load at the end of execute, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == fss_pkg::S_EXEC) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fss_pkg::S_EXEC) begin
      status_r  <= stat_c;
      rslot_r   <= rslot_c;
      rowner_r  <= rowner_ext[fss_pkg::OWNER_W-1:0];
      free_r    <= cap_r - cnt_nxt;
      occ_cnt_r <= cnt_nxt;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.status             = status_r;
  assign out_chan.result_slot        = rslot_r;
  assign out_chan.result_owner       = rowner_r;
  assign out_chan.free_count         = free_r;
  assign out_chan.occupied_count_out = occ_cnt_r;

endmodule

// ----- hw/rtl/fss_checker.sv -----
// Port-level checks for the slot owner table, bound to the top level.
// Depends on fss_pkg and the assertion macro header.
`include "first_free_slot_owner_table_macros.svh"

module fss_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fss_pkg::STAT_W-1:0]  status,
  input logic [fss_pkg::SLOT_W-1:0]  result_slot,
  input logic [fss_pkg::OWNER_W-1:0] result_owner,
  input logic [fss_pkg::SLOT_W-1:0]  free_count
);

  // An error result carries no slot and no owner
  `FSS_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && (status != fss_pkg::STAT_OK), (result_slot == '0) && (result_owner == '0))

  // A full table reports no free slot
  `FSS_ASSERT_IMP(a_full_none, clk, rst_n, out_valid && (status == fss_pkg::STAT_FULL), free_count == '0)

  // One transaction at a time: busy right after an accept
  `FSS_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)

  // A stalled result holds
  `FSS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(result_slot) && $stable(result_owner))

endmodule

bind first_free_slot_owner_table fss_checker u_fss_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .status       (out_chan.status),
  .result_slot  (out_chan.result_slot),
  .result_owner (out_chan.result_owner),
  .free_count   (out_chan.free_count)
);
